FILE: design/chdf_pkg.sv
package chdf_pkg;

    // Width and reset value of the distance limit register (sixteenths of a pixel).
    localparam int LIMIT_BITS = 12;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd32;

    // Width of the squared limit.
    localparam int THR2_BITS = 2 * LIMIT_BITS;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Input item kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_END_RD,
        ST_END_LD,
        ST_MUL_EXDY,
        ST_MUL_EYDX,
        ST_MUL_EXEX,
        ST_MUL_EYEY,
        ST_MUL_CROSS,
        ST_MUL_THR,
        ST_MUL_RHS,
        ST_COMPARE,
        ST_STEP_RD0,
        ST_STEP_RD1,
        ST_STEP_RD2,
        ST_EMIT
    } state_t;

endpackage

FILE: design/chdf_hull_ram.sv
module chdf_hull_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/chdf_mul_unit.sv
module chdf_mul_unit #(
    parameter int MW = 26
) (
    input  logic                   aclk,
    input  logic signed [MW-1:0]   op_a,
    input  logic signed [MW-1:0]   op_b,
    output logic signed [2*MW-1:0] prod
);

    logic signed [2*MW-1:0] prod_reg;

    // The shared multiplier: a product every cycle, registered.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/contour_hull_distance_filter.sv
// Contour hull distance filter.
// Items on the s_ channel either load a hull point (tuser action 0, with tuser first
// restarting the hull set) or test a contour point (action 1, first marking the first
// point of a contour). Every contour point gives one item on the m_ channel with the
// point, a keep flag and a status; a hull load gives a result only when the store is full.
// The threshold is written on the cfg_ channel, which is always ready; write it only
// while the block is idle.
// A hull load is written in the idle state and passes through the emit state only when
// the store is full. A contour point takes seven passes through the one shared multiplier
// and then the compare, and steps the edge back round the hull when it is the far end.
// On a first point the hull search reads and compares each hull entry examined, then
// fetches the edge end; a point of an unmatched contour goes straight to the emit state.
// One item is worked on at a time; s_tready is high only while the sequencer is idle.
// A finished result waits in the output register, so a stalled receiver holds only
// the next result, not the next input item.
// Reset (synchronous, aresetn low) empties the hull, resets the edge to the origin,
// clears the no-match flag and sets the threshold to 2.0 pixels. The hull store is not
// cleared; only written entries are ever read.
module contour_hull_distance_filter #(
    parameter int HULL_DEPTH = 256,
    parameter int COORD_BITS = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration: distance limit in sixteenths of a pixel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [chdf_pkg::LIMIT_BITS-1:0]         cfg_data,
    // Input items.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,  // point_x, point_y
    input  logic [1:0]                              s_tuser,  // action, first
    input  logic                                    s_tlast,  // last
    // Result items.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_tdata,  // out_x, out_y
    output logic [2:0]                              m_tuser,  // keep, status
    output logic                                    m_tlast   // out_last
);

    import chdf_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int PTW  = 2 * C;
    localparam int AW   = $clog2(HULL_DEPTH);
    localparam int CNTW = $clog2(HULL_DEPTH + 1);
    localparam int DW   = ((2 * C + 7) / 8) * 8;
    localparam int MW   = (2 * C + 2 > THR2_BITS + 1) ? 2 * C + 2 : THR2_BITS + 1;
    localparam int PRW  = 2 * MW;
    localparam int XW   = 2 * C + 2;
    localparam int LW   = 2 * C + 1;
    localparam int SQW  = 4 * C + 2;
    localparam int CMPW = (SQW + 8 > PRW) ? SQW + 8 : PRW;

    // Move back one hull point, wrapping round, or to the top when beyond the count.
    function automatic logic [AW-1:0] step_back(input logic [AW-1:0] pos,
                                                input logic [CNTW-1:0] cnt);
        logic [CNTW-1:0] top_idx;
        top_idx = cnt - 1'b1;
        if (pos == '0 || CNTW'(pos) >= cnt) begin
            return top_idx[AW-1:0];
        end
        return pos - 1'b1;
    endfunction

    state_t                 state_reg, state_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [PTW-1:0]         edge_start_reg, edge_start_next;
    logic [PTW-1:0]         edge_end_reg, edge_end_next;
    logic                   failed_reg, failed_next;
    logic [LIMIT_BITS-1:0]  limit_reg, limit_next;
    logic [PTW-1:0]         p_reg, p_next;
    logic                   last_reg, last_next;
    logic                   keep_reg, keep_next;
    logic [1:0]             status_reg, status_next;
    logic signed [XW-1:0]   acc_reg, acc_next;
    logic signed [XW-1:0]   cross_reg, cross_next;
    logic [LW-1:0]          len2_reg, len2_next;
    logic [SQW-1:0]         lhs_reg, lhs_next;
    logic [PTW-1:0]         out_p_reg, out_p_next;
    logic                   out_keep_reg, out_keep_next;
    logic                   out_last_reg, out_last_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [AW-1:0]          ram_rd_addr;
    logic [PTW-1:0]         ram_rd_data;

    logic signed [MW-1:0]   op_a, op_b;
    logic signed [PRW-1:0]  prod;

    logic signed [C:0]      ex, ey, dx, dy;
    logic signed [XW-1:0]   cross_neg;
    logic [LW-1:0]          mag;
    logic [CNTW-1:0]        cnt_m1;
    logic [AW-1:0]          cur_pos;
    logic [CNTW-1:0]        eff_count;
    logic [PTW-1:0]         in_point;
    logic                   in_accept;

    // Hull point store.
    chdf_hull_ram #(
        .DEPTH (HULL_DEPTH),
        .WIDTH (PTW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_point),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared multiplier.
    chdf_mul_unit #(
        .MW (MW)
    ) u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Edge and point differences; points are packed with x above y.
    assign ex = $signed({1'b0, edge_end_reg[PTW-1:C]}) - $signed({1'b0, edge_start_reg[PTW-1:C]});
    assign ey = $signed({1'b0, edge_end_reg[C-1:0]}) - $signed({1'b0, edge_start_reg[C-1:0]});
    assign dx = $signed({1'b0, p_reg[PTW-1:C]}) - $signed({1'b0, edge_start_reg[PTW-1:C]});
    assign dy = $signed({1'b0, p_reg[C-1:0]}) - $signed({1'b0, edge_start_reg[C-1:0]});

    // Magnitude of the cross product.
    assign cross_neg = -cross_reg;
    assign mag = cross_reg[XW-1] ? cross_neg[LW-1:0] : cross_reg[LW-1:0];

    // Current edge position clamped to the hull, for the edge step.
    assign cnt_m1  = count_reg - 1'b1;
    assign cur_pos = (CNTW'(pos_reg) < count_reg) ? pos_reg : cnt_m1[AW-1:0];

    assign in_point  = {s_tdata[C-1:0], s_tdata[PTW-1:C]};
    assign in_accept = s_tvalid && s_tready;
    assign eff_count = s_tuser[1] ? '0 : count_reg;

    // Multiplier operand selection.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_MUL_EXDY: begin
                op_a = MW'(ex);
                op_b = MW'(dy);
            end
            ST_MUL_EYDX: begin
                op_a = MW'(ey);
                op_b = MW'(dx);
            end
            ST_MUL_EXEX: begin
                op_a = MW'(ex);
                op_b = MW'(ex);
            end
            ST_MUL_EYEY: begin
                op_a = MW'(ey);
                op_b = MW'(ey);
            end
            ST_MUL_CROSS: begin
                op_a = signed'(MW'(mag));
                op_b = signed'(MW'(mag));
            end
            ST_MUL_THR: begin
                op_a = signed'(MW'(limit_reg));
                op_b = signed'(MW'(limit_reg));
            end
            ST_MUL_RHS: begin
                op_a = signed'(MW'(prod[THR2_BITS-1:0]));
                op_b = signed'(MW'(len2_reg));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequencer: next state, datapath updates and memory control.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        edge_start_next = edge_start_reg;
        edge_end_next   = edge_end_reg;
        failed_next     = failed_reg;
        p_next          = p_reg;
        last_next       = last_reg;
        keep_next       = keep_reg;
        status_next     = status_reg;
        acc_next        = acc_reg;
        cross_next      = cross_reg;
        len2_next       = len2_reg;
        lhs_next        = lhs_reg;
        out_p_next      = out_p_reg;
        out_keep_next   = out_keep_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = eff_count[AW-1:0];
        ram_rd_addr     = pos_reg;
        s_tready        = (state_reg == ST_IDLE);

        // The output register is emptied whenever the receiver takes the item.
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    p_next      = in_point;
                    last_next   = s_tlast;
                    keep_next   = 1'b0;
                    status_next = STATUS_OK;
                    if (s_tuser[0] == ACT_LOAD) begin
                        if (eff_count < CNTW'(HULL_DEPTH)) begin
                            ram_wr_en  = 1'b1;
                            count_next = eff_count + 1'b1;
                        end else begin
                            status_next = STATUS_OVERFLOW;
                            state_next  = ST_EMIT;
                        end
                    end else if (s_tuser[1]) begin
                        idx_next = '0;
                        if (count_reg == '0) begin
                            failed_next = 1'b1;
                            status_next = STATUS_NO_MATCH;
                            state_next  = ST_EMIT;
                        end else begin
                            state_next = ST_SRCH_RD;
                        end
                    end else if (failed_reg) begin
                        status_next = STATUS_NO_MATCH;
                        state_next  = ST_EMIT;
                    end else begin
                        state_next = ST_MUL_EXDY;
                    end
                end
            end
            // Hull search: read an entry, then compare it with the point.
            ST_SRCH_RD: begin
                ram_rd_addr = idx_reg;
                state_next  = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (ram_rd_data == p_reg) begin
                    failed_next     = 1'b0;
                    edge_start_next = p_reg;
                    pos_next        = step_back(idx_reg, count_reg);
                    state_next      = ST_END_RD;
                end else if (CNTW'(idx_reg) + 1'b1 == count_reg) begin
                    failed_next = 1'b1;
                    status_next = STATUS_NO_MATCH;
                    state_next  = ST_EMIT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_END_RD: begin
                ram_rd_addr = pos_reg;
                state_next  = ST_END_LD;
            end
            ST_END_LD: begin
                edge_end_next = ram_rd_data;
                state_next    = ST_MUL_EXDY;
            end
            // Distance test through the shared multiplier.
            ST_MUL_EXDY: begin
                state_next = ST_MUL_EYDX;
            end
            ST_MUL_EYDX: begin
                acc_next   = signed'(prod[XW-1:0]);
                state_next = ST_MUL_EXEX;
            end
            ST_MUL_EXEX: begin
                cross_next = acc_reg - signed'(prod[XW-1:0]);
                state_next = ST_MUL_EYEY;
            end
            ST_MUL_EYEY: begin
                acc_next   = signed'(prod[XW-1:0]);
                state_next = ST_MUL_CROSS;
            end
            ST_MUL_CROSS: begin
                len2_next  = acc_reg[LW-1:0] + prod[LW-1:0];
                state_next = ST_MUL_THR;
            end
            ST_MUL_THR: begin
                lhs_next   = prod[SQW-1:0];
                state_next = ST_MUL_RHS;
            end
            ST_MUL_RHS: begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                keep_next = (len2_reg != '0) &&
                            (CMPW'({lhs_reg, 8'h00}) < CMPW'(prod[PRW-1:0]));
                if (p_reg == edge_end_reg && count_reg != '0) begin
                    state_next = ST_STEP_RD0;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            // Edge step: fetch the new start, then the new far end.
            ST_STEP_RD0: begin
                ram_rd_addr = cur_pos;
                pos_next    = step_back(cur_pos, count_reg);
                state_next  = ST_STEP_RD1;
            end
            ST_STEP_RD1: begin
                edge_start_next = ram_rd_data;
                ram_rd_addr     = pos_reg;
                state_next      = ST_STEP_RD2;
            end
            ST_STEP_RD2: begin
                edge_end_next = ram_rd_data;
                state_next    = ST_EMIT;
            end
            // Hand the result to the output register once it is free.
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_p_next      = p_reg;
                    out_keep_next   = keep_reg;
                    out_last_next   = last_reg;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Distance limit register.
    always_comb begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Control and edge state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            edge_start_reg <= '0;
            edge_end_reg   <= '0;
            failed_reg     <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            edge_start_reg <= edge_start_next;
            edge_end_reg   <= edge_end_next;
            failed_reg     <= failed_next;
            limit_reg      <= limit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        last_reg       <= last_next;
        keep_reg       <= keep_next;
        status_reg     <= status_next;
        acc_reg        <= acc_next;
        cross_reg      <= cross_next;
        len2_reg       <= len2_next;
        lhs_reg        <= lhs_next;
        out_p_reg      <= out_p_next;
        out_keep_reg   <= out_keep_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // Result channel: x in the low bits of tdata, then y.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'({out_p_reg[C-1:0], out_p_reg[PTW-1:C]});
    assign m_tuser  = {out_status_reg, out_keep_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import chdf_pkg::*;

    localparam int HULL_DEPTH    = 256;
    localparam int COORD_BITS    = 12;
    localparam int DATA_BITS     = ((2*COORD_BITS+7)/8)*8;
    localparam int CMAX          = (1 << COORD_BITS) - 1;
    // Worst hull search over a full store, plus the slowest point and some margin.
    localparam int SETTLE_CYCLES = 2*HULL_DEPTH + 40;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;

    // Points are held as {x, y}, the same way the hull is searched.
    typedef logic [2*COORD_BITS-1:0] point_t;

    typedef struct {
        logic                  action;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  first;
        logic                  last;
    } stream_item_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  keep;
        logic                  last;
        logic [1:0]            status;
    } filter_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LIMIT_BITS-1:0] cfg_data  = LIMIT_RESET;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_BITS-1:0]  s_tdata   = '0;   // point_x, point_y
    logic [1:0]            s_tuser   = '0;   // action, first
    logic                  s_tlast   = 1'b0; // last
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_BITS-1:0]  m_tdata;          // out_x, out_y
    logic [2:0]            m_tuser;          // keep, status
    logic                  m_tlast;          // out_last

    contour_hull_distance_filter #(
        .HULL_DEPTH (HULL_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Stimulus queue and the pacing knobs of the current phase.
    stream_item_t pending_items[$];
    int           items_made    = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           hold_ask      = 0;
    int           hold_seen     = 0;
    int           hold_left     = 0;

    // Predicted filter state.
    point_t                hull_mem[HULL_DEPTH];
    int                    hull_len   = 0;
    int                    hull_pos   = 0;
    point_t                edge_from  = '0;
    point_t                edge_to    = '0;
    bit                    lost_track = 1'b0;
    logic [LIMIT_BITS-1:0] limit_now  = LIMIT_RESET;
    filter_result_t        awaited_results[$];
    int                    err_count    = 0;
    int                    quiet_cycles = 0;

    // Hull currently loaded, as the stimulus side knows it.
    point_t shape_pts[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Exact form of the altitude test: area^2 * 256 < limit^2 * length^2.
    function automatic bit close_to_edge(point_t s, point_t e, point_t p,
                                         logic [LIMIT_BITS-1:0] lim);
        longint            sx, sy, ex, ey, dx, dy, twice_area;
        longint unsigned   mag, len2, thr;
        sx = 64'(s[2*COORD_BITS-1:COORD_BITS]);
        sy = 64'(s[COORD_BITS-1:0]);
        ex = 64'(e[2*COORD_BITS-1:COORD_BITS]);
        ey = 64'(e[COORD_BITS-1:0]);
        dx = 64'(p[2*COORD_BITS-1:COORD_BITS]);
        dy = 64'(p[COORD_BITS-1:0]);
        ex = ex - sx;
        ey = ey - sy;
        dx = dx - sx;
        dy = dy - sy;
        twice_area = ex * dy - ey * dx;
        mag = (twice_area < 0) ? -twice_area : twice_area;
        len2 = ex * ex + ey * ey;
        thr = 64'(lim);
        if (len2 == 0)
            return 1'b0;
        return ((mag * mag) << 8) < thr * thr * len2;
    endfunction

    // One hull point backward, wrapping round the hull.
    function automatic int back_one(int pos);
        if (pos == 0 || pos >= hull_len)
            return hull_len - 1;
        return pos - 1;
    endfunction

    task automatic filter_point(input stream_item_t it, output bit produced,
                                output filter_result_t res);
        point_t p;
        int     cur;
        int     i;
        p = {it.x, it.y};
        produced = 1'b1;
        res.x = it.x;
        res.y = it.y;
        res.keep = 1'b0;
        res.last = it.last;
        res.status = STATUS_OK;
        if (it.action == ACT_LOAD) begin
            if (it.first)
                hull_len = 0;
            if (hull_len < HULL_DEPTH) begin
                hull_mem[hull_len] = p;
                hull_len++;
                produced = 1'b0;
            end else begin
                res.status = STATUS_OVERFLOW;
            end
        end else begin
            // The first point of a contour picks the starting edge from the hull.
            if (it.first) begin
                lost_track = 1'b1;
                for (i = 0; i < hull_len && lost_track; i++) begin
                    if (hull_mem[i] == p) begin
                        lost_track = 1'b0;
                        edge_from = p;
                        hull_pos = back_one(i);
                        edge_to = hull_mem[hull_pos];
                    end
                end
            end
            if (lost_track) begin
                res.status = STATUS_NO_MATCH;
            end else begin
                res.keep = close_to_edge(edge_from, edge_to, p, limit_now);
                if (p == edge_to && hull_len != 0) begin
                    cur = (hull_pos < hull_len) ? hull_pos : hull_len - 1;
                    edge_from = hull_mem[cur];
                    hull_pos = back_one(cur);
                    edge_to = hull_mem[hull_pos];
                end
            end
        end
    endtask

    // Input driver: presents the next pending item unless the sender idles.
    always @(posedge aclk) begin : drive_items
        stream_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {it.y, it.x};
                s_tuser <= {it.first, it.action};
                s_tlast <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver readiness with random stalls.
    always @(posedge aclk) begin
        m_tready <= aresetn && hold_left == 0 && $urandom_range(0, 99) >= stall_pct;
    end

    // Monitor: predicts on every accepted input item and checks every result item.
    always @(posedge aclk) begin : observe
        stream_item_t   it;
        filter_result_t want;
        bit             produced;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                limit_now = cfg_data;
            if (s_tvalid && s_tready) begin
                it.action = s_tuser[0];
                it.first = s_tuser[1];
                it.x = s_tdata[COORD_BITS-1:0];
                it.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
                it.last = s_tlast;
                filter_point(it, produced, want);
                if (produced)
                    awaited_results = {awaited_results, want};
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item x=%0d y=%0d",
                                              m_tdata[COORD_BITS-1:0],
                                              m_tdata[2*COORD_BITS-1:COORD_BITS]));
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_x", 16'(m_tdata[COORD_BITS-1:0]), 16'(want.x));
                    check_field("out_y", 16'(m_tdata[2*COORD_BITS-1:COORD_BITS]),
                                16'(want.y));
                    check_field("keep", 16'(m_tuser[0]), 16'(want.keep));
                    check_field("status", 16'(m_tuser[2:1]), 16'(want.status));
                    check_field("out_last", 16'(m_tlast), 16'(want.last));
                end
            end
            quiet_cycles <= ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
                             (m_tvalid && m_tready)) ? 0 : quiet_cycles + 1;
        end
    end

    task automatic add_item(input logic action, input int x, input int y,
                            input logic first, input logic last);
        stream_item_t it;
        it.action = action;
        it.x = x[COORD_BITS-1:0];
        it.y = y[COORD_BITS-1:0];
        it.first = first;
        it.last = last;
        pending_items = {pending_items, it};
        items_made++;
    endtask

    function automatic int pick_spread();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 8;
            4: return 40;
            default: return 300;
        endcase
    endfunction

    // A point somewhere along the edge from a to b, pushed off it by up to spread.
    function automatic point_t point_between(point_t a, point_t b, int spread);
        int ax, ay, bx, by, t, off, x, y;
        ax = int'(a[2*COORD_BITS-1:COORD_BITS]);
        ay = int'(a[COORD_BITS-1:0]);
        bx = int'(b[2*COORD_BITS-1:COORD_BITS]);
        by = int'(b[COORD_BITS-1:0]);
        t = $urandom_range(1, 15);
        off = $urandom_range(0, 2*spread);
        x = ax + ((bx - ax) * t) / 16 + off - spread;
        off = $urandom_range(0, 2*spread);
        y = ay + ((by - ay) * t) / 16 + off - spread;
        x = (x < 0) ? 0 : (x > CMAX) ? CMAX : x;
        y = (y < 0) ? 0 : (y > CMAX) ? CMAX : y;
        return {x[COORD_BITS-1:0], y[COORD_BITS-1:0]};
    endfunction

    // Loads a fresh hull of n points, spread over the whole range or a small box.
    task automatic load_hull(input int n);
        int span, bx, by, x, y, i;
        shape_pts.delete();
        case ($urandom_range(0, 2))
            0: span = CMAX;
            1: span = $urandom_range(8, 64);
            default: span = $urandom_range(64, 600);
        endcase
        bx = $urandom_range(0, CMAX - span);
        by = $urandom_range(0, CMAX - span);
        for (i = 0; i < n; i++) begin
            x = bx + $urandom_range(0, span);
            y = by + $urandom_range(0, span);
            if ($urandom_range(0, 19) == 0)
                x = $urandom_range(0, 1) ? CMAX : 0;
            if ($urandom_range(0, 19) == 0)
                y = $urandom_range(0, 1) ? CMAX : 0;
            if (i < HULL_DEPTH)
                shape_pts = {shape_pts, {x[COORD_BITS-1:0], y[COORD_BITS-1:0]}};
            add_item(ACT_LOAD, x, y, i == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Walks the hull backward from a random vertex, with points near each edge.
    task automatic trace_contour(input int skip_pct, input int spread);
        point_t path[$];
        int     n, cur, nxt, edges, inner, e, j;
        n = shape_pts.size();
        if (n == 0)
            return;
        cur = $urandom_range(0, n - 1);
        path = {path, shape_pts[cur]};
        edges = $urandom_range(1, (n < 12) ? n + 1 : 12);
        for (e = 0; e < edges; e++) begin
            nxt = (cur == 0) ? n - 1 : cur - 1;
            inner = $urandom_range(0, 4);
            for (j = 0; j < inner; j++)
                path = {path, point_between(shape_pts[cur], shape_pts[nxt], spread)};
            if ($urandom_range(0, 99) >= skip_pct)
                path = {path, shape_pts[nxt]};
            cur = nxt;
        end
        for (j = 0; j < path.size(); j++)
            add_item(ACT_TEST, int'(path[j][2*COORD_BITS-1:COORD_BITS]),
                     int'(path[j][COORD_BITS-1:0]), j == 0, j == path.size() - 1);
    endtask

    // Mostly well-formed hulls and contours; the rest broken sequences and noise.
    task automatic random_items(input int target);
        int     stop_at, r, k, n;
        point_t p;
        stop_at = items_made + target;
        while (items_made < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                if (shape_pts.size() == 0 || $urandom_range(0, 2) == 0)
                    load_hull($urandom_range(3, 12));
                repeat ($urandom_range(1, 3))
                    trace_contour(10, pick_spread());
            end else if (r < 74) begin
                // A contour whose first point is most likely not on the hull.
                add_item(ACT_TEST, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 1, 0);
                repeat ($urandom_range(0, 3))
                    add_item(ACT_TEST, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0, 0);
                add_item(ACT_TEST, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0, 1);
            end else if (r < 82) begin
                // Points with no first point, carrying on from the last edge.
                n = shape_pts.size();
                repeat ($urandom_range(1, 4)) begin
                    if (n != 0) begin
                        k = $urandom_range(0, n - 1);
                        p = $urandom_range(0, 1) ? shape_pts[k] :
                            point_between(shape_pts[k], shape_pts[(k + 1) % n], 2);
                    end else begin
                        p = {COORD_BITS'($urandom_range(0, CMAX)),
                             COORD_BITS'($urandom_range(0, CMAX))};
                    end
                    add_item(ACT_TEST, int'(p[2*COORD_BITS-1:COORD_BITS]),
                             int'(p[COORD_BITS-1:0]), 0, 1'($urandom_range(0, 1)));
                end
            end else if (r < 90) begin
                // The hull is reloaded part way through a contour.
                n = shape_pts.size();
                if (n != 0) begin
                    k = $urandom_range(0, n - 1);
                    p = shape_pts[k];
                    add_item(ACT_TEST, int'(p[2*COORD_BITS-1:COORD_BITS]),
                             int'(p[COORD_BITS-1:0]), 1, 0);
                    p = shape_pts[(k == 0) ? n - 1 : k - 1];
                    load_hull($urandom_range(1, 4));
                    add_item(ACT_TEST, int'(p[2*COORD_BITS-1:COORD_BITS]),
                             int'(p[COORD_BITS-1:0]), 0, 0);
                    p = shape_pts[0];
                    add_item(ACT_TEST, int'(p[2*COORD_BITS-1:COORD_BITS]),
                             int'(p[COORD_BITS-1:0]), 0, 1);
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    add_item(1'($urandom_range(0, 1)), $urandom_range(0, CMAX),
                             $urandom_range(0, CMAX), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Waits until every item is in and every result out, then for the block to settle.
    task automatic drain();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(input int limit, input int idle, input int stall,
                             input int target, input bit big_hull, input bit hold_off);
        drain();
        write_limit(LIMIT_BITS'(limit));
        send_idle_pct = idle;
        stall_pct = stall;
        // A full store followed by two loads that overflow it.
        if (big_hull) begin
            load_hull(HULL_DEPTH + 2);
            repeat (2) trace_contour(10, 2);
        end
        random_items(target);
        if (hold_off) begin
            repeat (20) @(negedge aclk);
            hold_ask++;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Before any hull: the reset edge, then a first point with an empty hull.
        add_item(ACT_TEST, 0, 0, 0, 0);
        add_item(ACT_TEST, CMAX, CMAX, 0, 1);
        add_item(ACT_TEST, 7, 9, 1, 0);
        add_item(ACT_TEST, 0, 0, 0, 1);
        // Square hull on the corners of the range.
        add_item(ACT_LOAD, 0, 0, 1, 0);
        add_item(ACT_LOAD, CMAX, 0, 0, 0);
        add_item(ACT_LOAD, CMAX, CMAX, 0, 0);
        add_item(ACT_LOAD, 0, CMAX, 0, 1);
        // Round two sides, with a point exactly two pixels off the edge.
        add_item(ACT_TEST, 0, 0, 1, 0);
        add_item(ACT_TEST, 1, 2000, 0, 0);
        add_item(ACT_TEST, 2, 100, 0, 0);
        add_item(ACT_TEST, 0, CMAX, 0, 0);
        add_item(ACT_TEST, 2048, CMAX - 1, 0, 0);
        add_item(ACT_TEST, CMAX, CMAX, 0, 0);
        add_item(ACT_TEST, CMAX, 2000, 0, 1);
        // A repeated vertex gives a zero-length starting edge.
        add_item(ACT_LOAD, 10, 10, 1, 0);
        add_item(ACT_LOAD, 50, 60, 0, 0);
        add_item(ACT_LOAD, 10, 10, 0, 0);
        add_item(ACT_TEST, 10, 10, 1, 0);
        add_item(ACT_TEST, 30, 35, 0, 0);
        // A one-point hull mid contour: the edge position wraps to the new hull.
        add_item(ACT_LOAD, 200, 300, 1, 0);
        add_item(ACT_TEST, 50, 60, 0, 1);

        run_phase(CMAX, 0, 0, 200, 1'b0, 1'b1);
        run_phase(0, 78, 0, 200, 1'b0, 1'b0);
        run_phase(1, 0, 78, 200, 1'b0, 1'b0);
        run_phase(LIMIT_RESET, 37, 37, 200, 1'b1, 1'b0);
        run_phase($urandom_range(2, 200), 0, 0, 200, 1'b0, 1'b0);
        run_phase($urandom_range(0, CMAX), 78, 0, 200, 1'b0, 1'b0);
        drain();

        if (err_count == 0)
            $display("contour_hull_distance_filter regression: pass");
        else
            $display("contour_hull_distance_filter regression: fail");
        $finish;
    end

    // Watchdog: ends the run when no item moves on any channel for too long.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
        $display("contour_hull_distance_filter regression: fail");
        $finish;
    end

endmodule
